[rtl/chip8_pkg.sv]
package chip8_pkg;

    localparam int unsigned MEM_BYTES  = 4096;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned ROWS       = 32;
    localparam int unsigned COLS       = 64;
    localparam int unsigned GLYPH      = 5;
    localparam logic [11:0] PC_RESET   = 12'd512;
    localparam logic [11:0] FONT_RESET = 12'd80;

    localparam logic [1:0] OPN_EXEC  = 2'd0;
    localparam logic [1:0] OPN_WRITE = 2'd1;
    localparam logic [1:0] OPN_ROW   = 2'd2;

    localparam logic [2:0] REG_FONT_BASE  = 3'd0;
    localparam logic [2:0] REG_START_ADDR = 3'd4;

    // step the datapath is told to perform
    typedef enum logic [3:0] {
        ST_NONE,
        ST_CLEAR,
        ST_ACCEPT,
        ST_START,
        ST_FHI,
        ST_FLO,
        ST_RX,
        ST_RY,
        ST_EX,
        ST_LOOP,
        ST_DONE
    } step_t;

    // multi-cycle instruction classes
    typedef enum logic [2:0] {
        K_SIMPLE,
        K_DRAW,
        K_BCD,
        K_STORE,
        K_LOAD
    } kind_t;

    typedef struct packed {
        step_t       step;
        logic [11:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  operation;
        kind_t       kind;
        logic [11:0] limit;
    } status_t;

    // decimal digits of a byte: [11:8] hundreds, [7:4] tens, [3:0] ones
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [7:0] rem;
        logic [7:0] ones;
        h = 4'd0;
        if (v >= 8'd200)
        begin
            h = 4'd2;
        end
        else if (v >= 8'd100)
        begin
            h = 4'd1;
        end
        rem = v - 8'(h * 8'd100);
        t = 4'd0;
        for (int j = 1; j < 10; j++)
        begin
            if (rem >= 8'(j * 10))
            begin
                t = 4'(j);
            end
        end
        ones = rem - 8'(t * 8'd10);
        return {h, t, ones[3:0]};
    endfunction

endpackage

[rtl/chip8_ctrl.sv]
module chip8_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  chip8_pkg::status_t status,
    output chip8_pkg::cmd_t    cmd
);
    import chip8_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_START = 10'b0000000100,
        S_FHI   = 10'b0000001000,
        S_FLO   = 10'b0000010000,
        S_RX    = 10'b0000100000,
        S_RY    = 10'b0001000000,
        S_EX    = 10'b0010000000,
        S_LOOP  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] cnt_reg, cnt_next;
    logic        mval_reg, mval_next;
    logic        load;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;
    assign load     = (state_reg == S_DONE) && (!mval_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mval_next  = mval_reg && !m_tready;
        cmd.step   = ST_NONE;
        cmd.cnt    = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.step = ST_CLEAR;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg == 12'hFFF)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.step   = ST_ACCEPT;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.step   = ST_START;
                state_next = (status.operation == OPN_EXEC) ? S_FHI : S_DONE;
            end
            S_FHI:
            begin
                cmd.step   = ST_FHI;
                state_next = S_FLO;
            end
            S_FLO:
            begin
                cmd.step   = ST_FLO;
                state_next = S_RX;
            end
            S_RX:
            begin
                cmd.step   = ST_RX;
                state_next = S_RY;
            end
            S_RY:
            begin
                cmd.step   = ST_RY;
                state_next = S_EX;
            end
            S_EX:
            begin
                cmd.step = ST_EX;
                cnt_next = 12'd0;
                state_next = (status.kind == K_SIMPLE) ? S_DONE : S_LOOP;
            end
            S_LOOP:
            begin
                cmd.step = ST_LOOP;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg == status.limit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    cmd.step   = ST_DONE;
                    mval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= 12'd0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mval_reg  <= mval_next;
        end
    end

endmodule

[rtl/chip8_dp.sv]
module chip8_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  chip8_pkg::cmd_t    cmd,
    output chip8_pkg::status_t status,
    input  logic [1:0]         in_operation,
    input  logic [11:0]        in_address,
    input  logic [7:0]         in_write_data,
    input  logic [15:0]        in_keys_pressed,
    input  logic [7:0]         in_random_byte,
    input  logic [4:0]         in_display_row_index,
    input  logic [11:0]        font_base,
    output logic [11:0]        program_counter,
    output logic               waiting_for_key,
    output logic               screen_changed,
    output logic [7:0]         delay_timer_value,
    output logic [7:0]         sound_timer_value,
    output logic [63:0]        display_row
);
    import chip8_pkg::*;

    // latched request
    logic [1:0]  opn_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [4:0]  rowi_reg;

    // machine state
    logic [7:0]  hi_reg;
    logic [15:0] op_reg;
    logic [7:0]  a_reg;
    logic [7:0]  b_reg;
    logic [11:0] pc_reg;
    logic [15:0] i_reg;
    logic [3:0]  sp_reg;
    logic [7:0]  dt_reg;
    logic [7:0]  st_reg;
    logic        seen_reg;
    logic        wait_reg;
    logic        chg_reg;
    logic [7:0]  v_reg [16];
    logic [11:0] stk_reg [16];
    logic [63:0] fb_reg [ROWS];

    // main memory
    logic [7:0]  mem_ram [MEM_BYTES];
    logic [7:0]  mem_q;
    logic [11:0] mem_raddr;
    logic [11:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_we;

    logic [3:0]   x, y, n, ra, key_low;
    logic [7:0]   nn, rd;
    logic [11:0]  nnn, pc_inc, pc_skip, loop_addr, cntm1;
    logic [4:0]   fb_idx;
    logic [63:0]  fb_rd, mask;
    logic [127:0] rot;
    logic [8:0]   sum;
    logic [11:0]  digits;
    logic         key_any, down;
    logic [3:0]   digit;

    assign x         = op_reg[11:8];
    assign y         = op_reg[7:4];
    assign n         = op_reg[3:0];
    assign nn        = op_reg[7:0];
    assign nnn       = op_reg[11:0];
    assign pc_inc    = pc_reg + 12'd2;
    assign pc_skip   = pc_reg + 12'd4;
    assign loop_addr = i_reg[11:0] + cmd.cnt;
    assign cntm1     = cmd.cnt - 12'd1;
    assign sum       = {1'b0, a_reg} + {1'b0, b_reg};
    assign digits    = bcd_digits(a_reg);
    assign down      = keys_reg[a_reg[3:0]];

    // decode of multi-cycle instructions
    always_comb
    begin
        status.operation = opn_reg;
        status.kind      = K_SIMPLE;
        status.limit     = 12'd0;
        if (op_reg[15:12] == 4'hD)
        begin
            status.kind  = K_DRAW;
            status.limit = {8'd0, n};
        end
        else if (op_reg[15:12] == 4'hF && nn == 8'h33)
        begin
            status.kind  = K_BCD;
            status.limit = 12'd2;
        end
        else if (op_reg[15:12] == 4'hF && nn == 8'h55)
        begin
            status.kind  = K_STORE;
            status.limit = {8'd0, x};
        end
        else if (op_reg[15:12] == 4'hF && nn == 8'h65)
        begin
            status.kind  = K_LOAD;
            status.limit = {8'd0, x} + 12'd1;
        end
    end

    // lowest held key
    always_comb
    begin
        key_low = 4'd0;
        key_any = |keys_reg;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                key_low = 4'(k);
            end
        end
    end

    // single register-file read port
    always_comb
    begin
        priority case (cmd.step)
            ST_RX:   ra = hi_reg[3:0];
            ST_RY:   ra = y;
            ST_LOOP: ra = cmd.cnt[3:0];
            default: ra = 4'd0;
        endcase
    end
    assign rd = v_reg[ra];

    // frame buffer row select and sprite placement
    assign fb_idx = (cmd.step == ST_LOOP) ? (b_reg[4:0] + cntm1[4:0]) : rowi_reg;
    assign fb_rd  = fb_reg[fb_idx];
    assign rot    = {mem_q, 56'd0, mem_q, 56'd0} >> a_reg[5:0];
    assign mask   = rot[63:0];

    always_comb
    begin
        unique case (cmd.cnt[1:0])
            2'd0:    digit = digits[11:8];
            2'd1:    digit = digits[7:4];
            default: digit = digits[3:0];
        endcase
    end

    // memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = loop_addr;
        mem_wdata = 8'd0;
        mem_raddr = loop_addr;
        priority case (cmd.step)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cmd.cnt;
            end
            ST_START:
            begin
                mem_we    = (opn_reg == OPN_WRITE);
                mem_waddr = addr_reg;
                mem_wdata = wdata_reg;
            end
            ST_FHI:
            begin
                mem_raddr = pc_reg;
            end
            ST_FLO:
            begin
                mem_raddr = pc_reg + 12'd1;
            end
            ST_LOOP:
            begin
                if (status.kind == K_BCD)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {4'd0, digit};
                end
                else if (status.kind == K_STORE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd;
                end
            end
            default:
            begin
                mem_raddr = pc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_ram[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem_ram[mem_raddr];
    end

    // request capture and output register
    always_ff @(posedge clk)
    begin
        if (cmd.step == ST_ACCEPT)
        begin
            opn_reg   <= in_operation;
            addr_reg  <= in_address;
            wdata_reg <= in_write_data;
            keys_reg  <= in_keys_pressed;
            rnd_reg   <= in_random_byte;
            rowi_reg  <= in_display_row_index;
        end
        if (cmd.step == ST_FLO)
        begin
            hi_reg <= mem_q;
        end
        if (cmd.step == ST_RX)
        begin
            op_reg <= {hi_reg, mem_q};
            a_reg  <= rd;
        end
        if (cmd.step == ST_RY)
        begin
            b_reg <= rd;
        end
        if (cmd.step == ST_DONE)
        begin
            program_counter   <= pc_reg;
            waiting_for_key   <= wait_reg;
            screen_changed    <= chg_reg;
            delay_timer_value <= dt_reg;
            sound_timer_value <= st_reg;
            display_row       <= (opn_reg == OPN_ROW) ? fb_rd : 64'd0;
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_RESET;
            i_reg    <= 16'd0;
            sp_reg   <= 4'd0;
            dt_reg   <= 8'd0;
            st_reg   <= 8'd0;
            seen_reg <= 1'b0;
            wait_reg <= 1'b0;
            chg_reg  <= 1'b0;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k]   <= 8'd0;
                stk_reg[k] <= 12'd0;
            end
            for (int r = 0; r < ROWS; r++)
            begin
                fb_reg[r] <= 64'd0;
            end
        end
        else
        begin
            priority case (cmd.step)
                ST_START:
                begin
                    wait_reg <= 1'b0;
                    chg_reg  <= 1'b0;
                end
                ST_EX:
                begin
                    pc_reg <= pc_inc;
                    unique case (op_reg[15:12])
                        4'h0:
                        begin
                            if (op_reg == 16'h00E0)
                            begin
                                for (int r = 0; r < ROWS; r++)
                                begin
                                    fb_reg[r] <= 64'd0;
                                end
                                chg_reg <= 1'b1;
                            end
                            else if (op_reg == 16'h00EE)
                            begin
                                sp_reg <= sp_reg - 4'd1;
                                pc_reg <= stk_reg[sp_reg - 4'd1];
                            end
                        end
                        4'h1: pc_reg <= nnn;
                        4'h2:
                        begin
                            stk_reg[sp_reg] <= pc_inc;
                            sp_reg <= sp_reg + 4'd1;
                            pc_reg <= nnn;
                        end
                        4'h3: if (a_reg == nn) pc_reg <= pc_skip;
                        4'h4: if (a_reg != nn) pc_reg <= pc_skip;
                        4'h5: if (a_reg == b_reg) pc_reg <= pc_skip;
                        4'h6: v_reg[x] <= nn;
                        4'h7: v_reg[x] <= a_reg + nn;
                        4'h8:
                        begin
                            priority case (n)
                                4'h0: v_reg[x] <= b_reg;
                                4'h1:
                                begin
                                    v_reg[x]  <= a_reg | b_reg;
                                    v_reg[15] <= 8'd0;
                                end
                                4'h2:
                                begin
                                    v_reg[x]  <= a_reg & b_reg;
                                    v_reg[15] <= 8'd0;
                                end
                                4'h3:
                                begin
                                    v_reg[x]  <= a_reg ^ b_reg;
                                    v_reg[15] <= 8'd0;
                                end
                                4'h4:
                                begin
                                    v_reg[x]  <= sum[7:0];
                                    v_reg[15] <= {7'd0, sum[8]};
                                end
                                4'h5:
                                begin
                                    v_reg[x]  <= a_reg - b_reg;
                                    v_reg[15] <= {7'd0, a_reg > b_reg};
                                end
                                4'h6:
                                begin
                                    v_reg[x]  <= {1'b0, a_reg[7:1]};
                                    v_reg[15] <= {7'd0, a_reg[0]};
                                end
                                4'h7:
                                begin
                                    v_reg[x]  <= b_reg - a_reg;
                                    v_reg[15] <= {7'd0, b_reg > a_reg};
                                end
                                4'hE:
                                begin
                                    v_reg[x]  <= {a_reg[6:0], 1'b0};
                                    v_reg[15] <= {7'd0, a_reg[7]};
                                end
                                default: ;
                            endcase
                        end
                        4'h9: if (a_reg != b_reg) pc_reg <= pc_skip;
                        4'hA: i_reg <= {4'd0, nnn};
                        4'hB: pc_reg <= nnn + {4'd0, rd};
                        4'hC: v_reg[x] <= rnd_reg & nn;
                        4'hD: v_reg[15] <= 8'd0;
                        4'hE:
                        begin
                            if ((nn == 8'h9E && down) || (nn == 8'hA1 && !down))
                            begin
                                pc_reg <= pc_skip;
                            end
                        end
                        4'hF:
                        begin
                            priority case (nn)
                                8'h07: v_reg[x] <= dt_reg;
                                8'h0A:
                                begin
                                    // key wait: press then release
                                    if (key_any)
                                    begin
                                        v_reg[x] <= {4'd0, key_low};
                                        seen_reg <= 1'b1;
                                        wait_reg <= 1'b1;
                                        pc_reg   <= pc_reg;
                                    end
                                    else if (seen_reg)
                                    begin
                                        seen_reg <= 1'b0;
                                    end
                                    else
                                    begin
                                        wait_reg <= 1'b1;
                                        pc_reg   <= pc_reg;
                                    end
                                end
                                8'h15: dt_reg <= a_reg;
                                8'h18: st_reg <= a_reg;
                                8'h1E: i_reg <= i_reg + {8'd0, a_reg};
                                8'h29: i_reg <= 16'({8'd0, a_reg} * 16'(GLYPH))
                                                + {4'd0, font_base};
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                ST_LOOP:
                begin
                    priority case (status.kind)
                        K_DRAW:
                        begin
                            if (cmd.cnt != 12'd0)
                            begin
                                fb_reg[fb_idx] <= fb_rd ^ mask;
                                if ((fb_rd & mask) != 64'd0)
                                begin
                                    v_reg[15] <= 8'd1;
                                end
                                if (mask != 64'd0)
                                begin
                                    chg_reg <= 1'b1;
                                end
                            end
                        end
                        K_LOAD:
                        begin
                            if (cmd.cnt != 12'd0)
                            begin
                                v_reg[cntm1[3:0]] <= mem_q;
                            end
                            if (cmd.cnt == status.limit)
                            begin
                                i_reg <= i_reg + {12'd0, x} + 16'd1;
                            end
                        end
                        K_STORE:
                        begin
                            if (cmd.cnt == status.limit)
                            begin
                                i_reg <= i_reg + {12'd0, x} + 16'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

[rtl/chip8_instruction_execute.sv]
// chip-8 interpreter core. each request on the slave stream runs one instruction out of the
// internal 4 KiB memory, writes one program byte, or reads one 64-pixel display row, and gives
// exactly one result on the master stream. after reset the core sweeps the program memory to
// zero, one byte a cycle, and takes no request until that pass is over (apb writes are taken
// meanwhile). an accepted request walks a sequencer: a byte write or row read passes start
// and result, an ordinary instruction passes a fetch of two bytes from the single-read memory
// port, two register-file reads, execute and result. draw adds a loop over the sprite rows,
// register store and load one over v0 to vx, the decimal split one over its hundreds, tens
// and ones digits, each row or byte going one at a time through the memory port. the next
// request is taken while a result still waits on the master side. timers are only loaded and
// read here; delay and sound counters are not decremented by this block. no font is preloaded.
module chip8_instruction_execute (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], address[13:2], write_data[21:14], keys_pressed[37:22],
    // random_byte[45:38], display_row_index[50:46], zero fill
    input  logic [55:0] s_tdata,
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // program_counter[11:0], waiting_for_key[12], screen_changed[13],
    // delay_timer_value[21:14], sound_timer_value[29:22], display_row[93:30], zero fill
    output logic [95:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import chip8_pkg::*;

    chip8_pkg::cmd_t    cmd;
    chip8_pkg::status_t status;

    logic [11:0] font_reg;
    logic [11:0] start_reg;
    logic [11:0] pc_out;
    logic        wait_out;
    logic        chg_out;
    logic [7:0]  dt_out;
    logic [7:0]  st_out;
    logic [63:0] row_out;

    // register file: font base at 0, start address at 4
    assign pready = 1'b1;
    assign prdata = {20'd0, (paddr == REG_START_ADDR) ? start_reg : font_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_reg  <= FONT_RESET;
            start_reg <= PC_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2])
            begin
                start_reg <= pwdata[11:0];
            end
            else
            begin
                font_reg <= pwdata[11:0];
            end
        end
    end

    chip8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    chip8_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .in_operation         (s_tdata[1:0]),
        .in_address           (s_tdata[13:2]),
        .in_write_data        (s_tdata[21:14]),
        .in_keys_pressed      (s_tdata[37:22]),
        .in_random_byte       (s_tdata[45:38]),
        .in_display_row_index (s_tdata[50:46]),
        .font_base            (font_reg),
        .program_counter      (pc_out),
        .waiting_for_key      (wait_out),
        .screen_changed       (chg_out),
        .delay_timer_value    (dt_out),
        .sound_timer_value    (st_out),
        .display_row          (row_out)
    );

    assign m_tdata = {2'd0, row_out, st_out, dt_out, chg_out, wait_out, pc_out};

endmodule
